// ----- sv/chm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_NODES  = 1024;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 8;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int PTR_W  = NODE_W + 1;           // extra bit: null
    localparam int CNT_W  = $clog2(POOL_NODES + 1);
    localparam int SIZE_W = $clog2(MAX_BUCKETS + 1);
    localparam int CMD_W  = 2 + KEY_BITS + VALUE_BITS;
    localparam int RES_W  = 2 + VALUE_BITS;
    localparam int IN_TDATA_W  = ((CMD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]            func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] found_value;
    } res_t;
endpackage
`default_nettype wire

// ----- sv/chained_hash_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Dir | tdata fields (low bit up)
// s_axis    | in  | func[1:0], key[33:2], value[41:34], zero pad to 48
// m_axis    | out | status[1:0], found_value[9:2], zero pad to 16
// Lookup/remove walk the bucket chain node by node and stop at a key match; insert
// pushes a new node on the bucket head. An insert that doubles the table then clears
// the new heads, walks the old buckets moving each node, and copies the heads back.
// After reset a sweep fills the free stack and nulls bucket heads; the back end takes
// no command then, up to two transfers queue.
// A two-deep command queue lets input transfers land while the back end works; a result
// not yet taken holds the back end, the queue fills and s_axis_tready drops.
module chained_hash_map (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [chm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // func, key, value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [chm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata   // status, found_value
);
    import chm_pkg::*;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t r_res;

    chm_front u_front (
        .aclk, .aresetn, .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_data(s_axis_tdata), .q_valid, .q_ready, .q_cmd
    );
    chm_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_res
    );
    assign m_axis_tdata = OUT_TDATA_W'({r_res.found_value, r_res.status});
endmodule
`default_nettype wire

// ----- sv/chm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input field unpacking plus 2-entry command queue.
module chm_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [chm_pkg::IN_TDATA_W-1:0]      s_data,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output chm_pkg::cmd_t                            q_cmd
);
    import chm_pkg::*;
    cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t in_cmd;

    assign in_cmd.func  = s_data[1:0];
    assign in_cmd.key   = s_data[2 +: KEY_BITS];
    assign in_cmd.value = s_data[2 + KEY_BITS +: VALUE_BITS];
    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                mem_reg[wp_reg] <= in_cmd;
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(s_valid && s_ready) - 2'(q_valid && q_ready);
        end
    end
endmodule
`default_nettype wire

// ----- sv/chm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Executes one command at a time against node / bucket memories.
module chm_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  chm_pkg::cmd_t      q_cmd,
    output logic               r_valid,
    input  wire logic          r_ready,
    output chm_pkg::res_t      r_res
);
    import chm_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HEAD, S_NODE, S_CHK, S_INS, S_RCLR, S_RHEAD,
        S_RNODE, S_RREAD, S_RMOVE, S_RCOPY, S_DONE
    } state_t;

    // memories
    logic [PTR_W-1:0]      head_mem [MAX_BUCKETS];
    logic [PTR_W-1:0]      newh_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0]   key_mem  [POOL_NODES];
    logic [VALUE_BITS-1:0] val_mem  [POOL_NODES];
    logic [PTR_W-1:0]      next_mem [POOL_NODES];
    logic [NODE_W-1:0]     free_mem [POOL_NODES];

    state_t state_reg;
    cmd_t cmd_reg;
    logic [SIZE_W:0]   clr_reg;          // sweep counter
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  top_reg, count_reg;
    logic [PTR_W-1:0]  cur_reg, prev_reg, rd_head_reg, nh_reg;
    logic [KEY_BITS-1:0]   nkey_reg;
    logic [VALUE_BITS-1:0] nval_reg;
    logic [PTR_W-1:0]      nnext_reg;
    logic [NODE_W-1:0]     fnode_reg;
    logic [BKT_W-1:0]  bkt_reg, nb_reg;
    res_t res_reg;
    logic out_v_reg;

    logic [BKT_W-1:0] mask;
    assign mask = BKT_W'(size_reg - SIZE_W'(1));

    assign q_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign r_valid = out_v_reg;
    assign r_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; clr_reg <= '0; size_reg <= SIZE_W'(1);
            top_reg <= CNT_W'(POOL_NODES); count_reg <= '0; out_v_reg <= 1'b0;
        end else begin
            if (out_v_reg && r_ready) out_v_reg <= 1'b0;
            case (state_reg)
                S_CLR: begin
                    // clear heads and fill free stack
                    if (clr_reg < (SIZE_W+1)'(MAX_BUCKETS))
                        head_mem[clr_reg[BKT_W-1:0]] <= NIL;
                    if (clr_reg < (SIZE_W+1)'(POOL_NODES))
                        free_mem[clr_reg[NODE_W-1:0]] <=
                            NODE_W'(POOL_NODES - 1) - clr_reg[NODE_W-1:0];
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SIZE_W+1)'(MAX_BUCKETS > POOL_NODES ?
                                               MAX_BUCKETS - 1 : POOL_NODES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_valid && !out_v_reg) begin
                        cmd_reg <= q_cmd;
                        bkt_reg <= q_cmd.key[BKT_W-1:0] & mask;
                        rd_head_reg <= head_mem[q_cmd.key[BKT_W-1:0] & mask];
                        if (top_reg != '0)
                            fnode_reg <= free_mem[NODE_W'(top_reg - CNT_W'(1))];
                        prev_reg <= NIL;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    cur_reg <= rd_head_reg;
                    if (cmd_reg.func == FN_INSERT && top_reg == '0)
                        res_reg <= '{status: ST_FULL, found_value: '0};
                    else
                        res_reg <= '{status: ST_MISS, found_value: '0};
                    case (cmd_reg.func)
                        FN_INSERT: begin
                            if (top_reg == '0) state_reg <= S_DONE;
                            else state_reg <= S_INS;
                        end
                        FN_LOOKUP, FN_REMOVE: state_reg <= S_NODE;
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_NODE: begin
                    if (cur_reg == NIL) state_reg <= S_DONE;
                    else begin
                        nkey_reg  <= key_mem[cur_reg[NODE_W-1:0]];
                        nval_reg  <= val_mem[cur_reg[NODE_W-1:0]];
                        nnext_reg <= next_mem[cur_reg[NODE_W-1:0]];
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (nkey_reg == cmd_reg.key) begin
                        res_reg.status <= ST_OK;
                        if (cmd_reg.func == FN_LOOKUP) res_reg.found_value <= nval_reg;
                        else begin
                            if (prev_reg == NIL) head_mem[bkt_reg] <= nnext_reg;
                            else next_mem[prev_reg[NODE_W-1:0]] <= nnext_reg;
                            free_mem[NODE_W'(top_reg)] <= cur_reg[NODE_W-1:0];
                            top_reg <= top_reg + CNT_W'(1);
                            count_reg <= count_reg - CNT_W'(1);
                        end
                        state_reg <= S_DONE;
                    end else begin
                        prev_reg <= cur_reg;
                        cur_reg <= nnext_reg;
                        state_reg <= S_NODE;
                    end
                end
                S_INS: begin
                    key_mem[fnode_reg]  <= cmd_reg.key;
                    val_mem[fnode_reg]  <= cmd_reg.value;
                    next_mem[fnode_reg] <= rd_head_reg;
                    head_mem[bkt_reg]   <= {1'b0, fnode_reg};
                    top_reg <= top_reg - CNT_W'(1);
                    count_reg <= count_reg + CNT_W'(1);
                    res_reg.status <= ST_OK;
                    if (SIZE_W'(count_reg + CNT_W'(1)) >= size_reg &&
                        size_reg <= SIZE_W'(MAX_BUCKETS / 2)) begin
                        clr_reg <= '0;
                        state_reg <= S_RCLR;
                    end else state_reg <= S_DONE;
                end
                S_RCLR: begin
                    newh_mem[clr_reg[BKT_W-1:0]] <= NIL;
                    if (clr_reg == (SIZE_W+1)'(2 * size_reg - 1)) begin
                        clr_reg <= '0;
                        state_reg <= S_RHEAD;
                    end else begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_RHEAD: begin
                    // walk old bucket clr_reg
                    if (clr_reg == (SIZE_W+1)'(size_reg)) begin
                        size_reg <= SIZE_W'(2 * size_reg);
                        clr_reg <= '0;
                        state_reg <= S_RCOPY;
                    end else begin
                        cur_reg <= head_mem[clr_reg[BKT_W-1:0]];
                        state_reg <= S_RNODE;
                    end
                end
                S_RNODE: begin
                    if (cur_reg == NIL) begin
                        clr_reg <= clr_reg + 1'b1;
                        state_reg <= S_RHEAD;
                    end else begin
                        nnext_reg <= next_mem[cur_reg[NODE_W-1:0]];
                        nb_reg <= key_mem[cur_reg[NODE_W-1:0]][BKT_W-1:0]
                                  & BKT_W'(2 * size_reg - 1);
                        state_reg <= S_RREAD;
                    end
                end
                S_RREAD: begin
                    // fetch current head of the new bucket
                    nh_reg <= newh_mem[nb_reg];
                    state_reg <= S_RMOVE;
                end
                S_RMOVE: begin
                    next_mem[cur_reg[NODE_W-1:0]] <= nh_reg;
                    newh_mem[nb_reg] <= cur_reg;
                    cur_reg <= nnext_reg;
                    state_reg <= S_RNODE;
                end
                S_RCOPY: begin
                    head_mem[clr_reg[BKT_W-1:0]] <= newh_mem[clr_reg[BKT_W-1:0]];
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SIZE_W+1)'(size_reg - 1)) state_reg <= S_DONE;
                end
                S_DONE: begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- bench/chained_hash_map_tb.sv -----
`timescale 1ns / 1ps
module chained_hash_map_tb;
    import chm_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;   // reserved code, block answers it with a miss
    localparam int WATCHDOG_LIMIT = 60000;     // rehash at full size plus reset sweep fit easily
    localparam int HOLD_CYCLES = 400;          // long receiver hold-off
    localparam int KEY_HIST = 256;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;    // func, key, value
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // status, found_value

    chained_hash_map DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---- shadow map state ----
    int unsigned sh_head [MAX_BUCKETS];
    logic [KEY_BITS-1:0] sh_key [POOL_NODES];
    logic [VALUE_BITS-1:0] sh_val [POOL_NODES];
    int unsigned sh_next [POOL_NODES];
    int unsigned sh_free [POOL_NODES];
    int unsigned sh_free_top, sh_count, sh_size;

    res_t expected_results[$];
    logic [KEY_BITS-1:0] key_hist [KEY_HIST];
    int key_hist_n = 0;

    int errors = 0;
    int n_sent = 0, n_recv = 0, n_full = 0, n_hit = 0, n_miss = 0, n_grow = 0;
    bit done_sending = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    function automatic void map_reset();
        for (int i = 0; i < MAX_BUCKETS; i++) sh_head[i] = POOL_NODES;
        for (int i = 0; i < POOL_NODES; i++) begin
            sh_next[i] = POOL_NODES;
            sh_free[i] = POOL_NODES - 1 - i;
        end
        sh_free_top = POOL_NODES;
        sh_count = 0;
        sh_size = 1;
    endfunction

    // Rebuild chains into a doubled table: old buckets low to high, each chain
    // from its head, every node pushed on the head of its new bucket.
    function automatic void map_grow(int unsigned old_size);
        int unsigned heads [MAX_BUCKETS];
        int unsigned n, nx, nb;
        for (int b = 0; b < MAX_BUCKETS; b++) heads[b] = POOL_NODES;
        for (int unsigned b = 0; b < old_size; b++) begin
            n = sh_head[b];
            while (n < POOL_NODES) begin
                nx = sh_next[n];
                nb = sh_key[n] & (sh_size - 1);
                sh_next[n] = heads[nb];
                heads[nb] = n;
                n = nx;
            end
        end
        sh_head = heads;
    endfunction

    function automatic res_t map_apply(cmd_t c);
        res_t r;
        int unsigned b, n, prev;
        r.status = ST_MISS;
        r.found_value = '0;
        b = c.key & (sh_size - 1);
        case (c.func)
            FN_INSERT: begin
                if (sh_free_top == 0) begin
                    r.status = ST_FULL;
                end else begin
                    sh_free_top--;
                    n = sh_free[sh_free_top];
                    sh_key[n] = c.key;
                    sh_val[n] = c.value;
                    sh_next[n] = sh_head[b];
                    sh_head[b] = n;
                    sh_count++;
                    if (sh_count >= sh_size && sh_size * 2 <= MAX_BUCKETS) begin
                        sh_size = sh_size * 2;
                        map_grow(sh_size / 2);
                        n_grow++;
                    end
                    r.status = ST_OK;
                end
            end
            FN_LOOKUP: begin
                n = sh_head[b];
                while (n < POOL_NODES) begin
                    if (sh_key[n] == c.key) begin
                        r.status = ST_OK;
                        r.found_value = sh_val[n];
                        break;
                    end
                    n = sh_next[n];
                end
            end
            FN_REMOVE: begin
                prev = POOL_NODES;
                n = sh_head[b];
                while (n < POOL_NODES) begin
                    if (sh_key[n] == c.key) begin
                        if (prev < POOL_NODES) sh_next[prev] = sh_next[n];
                        else sh_head[b] = sh_next[n];
                        sh_free[sh_free_top] = n;
                        sh_free_top++;
                        sh_count--;
                        r.status = ST_OK;
                        break;
                    end
                    prev = n;
                    n = sh_next[n];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, res_t got, res_t want);
        errors++;
        if (errors <= 30)
            $display("MISMATCH %s: got status %0d value %02h, want status %0d value %02h",
                     what, got.status, got.found_value, want.status, want.found_value);
    endtask

    // ---- sender: bursts with random gaps ----
    int burst_left = 0;

    task automatic send_cmd(cmd_t c, bit typed, res_t typed_res);
        res_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - CMD_W){1'b0}}, c.value, c.key, c.func};
        do @(posedge aclk); while (!s_axis_tready);
        r = map_apply(c);
        if (c.func == FN_INSERT) begin
            key_hist[key_hist_n % KEY_HIST] = c.key;
            key_hist_n++;
        end
        expected_results.push_back(typed ? typed_res : r);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: if (key_hist_n > 0)
                return key_hist[$urandom_range(0, (key_hist_n < KEY_HIST ?
                                                   key_hist_n : KEY_HIST) - 1)];
            5: return KEY_BITS'($urandom_range(0, 15));   // dense low keys, long chains
            default: ;
        endcase
        return $urandom();
    endfunction

    function automatic cmd_t rand_cmd(int ins_weight);
        cmd_t c;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_weight) c.func = FN_INSERT;
        else if (roll < ins_weight + (100 - ins_weight) / 2) c.func = FN_LOOKUP;
        else if (roll < 98) c.func = FN_REMOVE;
        else c.func = FN_UNUSED;
        c.key = pick_key();
        c.value = VALUE_BITS'($urandom_range(0, 255));
        return c;
    endfunction

    // ---- directed table ----
    typedef struct {
        logic [1:0] func;
        logic [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0] value;
        bit typed;
        logic [1:0] status;
        logic [VALUE_BITS-1:0] fv;
    } step_row_t;

    step_row_t plan [] = '{
        '{FN_LOOKUP, 32'h0,        8'h00, 1, ST_MISS, 8'h00},  // empty map
        '{FN_REMOVE, 32'hFFFFFFFF, 8'hFF, 1, ST_MISS, 8'h00},  // remove from empty bucket
        '{FN_UNUSED, 32'h5,        8'hA5, 1, ST_MISS, 8'h00},  // reserved code
        '{FN_INSERT, 32'h0,        8'h00, 1, ST_OK,   8'h00},
        '{FN_INSERT, 32'hFFFFFFFF, 8'hFF, 1, ST_OK,   8'h00},
        '{FN_LOOKUP, 32'hFFFFFFFF, 8'h00, 1, ST_OK,   8'hFF},
        '{FN_LOOKUP, 32'h0,        8'h33, 1, ST_OK,   8'h00},  // value ignored on lookup
        '{FN_INSERT, 32'h0,        8'h5A, 1, ST_OK,   8'h00},  // duplicate key
        '{FN_LOOKUP, 32'h0,        8'h00, 1, ST_OK,   8'h5A},  // newest copy wins
        '{FN_REMOVE, 32'h0,        8'h00, 1, ST_OK,   8'h00},
        '{FN_LOOKUP, 32'h0,        8'h00, 1, ST_OK,   8'h00},  // older copy shows again
        '{FN_INSERT, 32'h4,        8'h44, 0, 0, 0},
        '{FN_INSERT, 32'h8,        8'h88, 0, 0, 0},
        '{FN_INSERT, 32'hC,        8'hCC, 0, 0, 0},
        '{FN_INSERT, 32'h10,       8'h10, 0, 0, 0},
        '{FN_REMOVE, 32'h10,       8'h00, 0, 0, 0},            // chain head
        '{FN_LOOKUP, 32'hC,        8'h00, 0, 0, 0},
        '{FN_REMOVE, 32'h4,        8'h00, 0, 0, 0},            // end of chain
        '{FN_LOOKUP, 32'h8,        8'h00, 0, 0, 0},
        '{FN_REMOVE, 32'h1234,     8'h00, 0, 0, 0},            // absent key
        '{FN_LOOKUP, 32'h80000001, 8'h00, 0, 0, 0},
        '{FN_INSERT, 32'h80000000, 8'h01, 0, 0, 0},
        '{FN_LOOKUP, 32'h80000000, 8'h00, 0, 0, 0}
    };

    initial begin
        cmd_t c;
        res_t tr;
        map_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            c.func = plan[i].func;
            c.key = plan[i].key;
            c.value = plan[i].value;
            tr.status = plan[i].status;
            tr.found_value = plan[i].fv;
            send_cmd(c, plan[i].typed, tr);
        end

        // mixed traffic on a growing map
        for (int i = 0; i < 700; i++) begin
            if (i == 200) hold_req = 1'b1;
            send_cmd(rand_cmd(45), 1'b0, tr);
        end
        // fill: mostly inserts until the pool runs dry and table hits its cap
        for (int i = 0; i < 700 && n_full < 40; i++)
            send_cmd(rand_cmd(90), 1'b0, tr);
        // drain and refill around the full point
        for (int i = 0; i < 500; i++)
            send_cmd(rand_cmd(i < 250 ? 20 : 60), 1'b0, tr);

        s_axis_tvalid <= 1'b0;
        done_sending = 1'b1;
    end

    // ---- receiver: own stall pattern plus one long hold-off ----
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ---- result checker ----
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.found_value = m_axis_tdata[2 +: VALUE_BITS];
            n_recv++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("MISMATCH: result transfer with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) report_mismatch("status", got, want);
                else if (got.found_value != want.found_value)
                    report_mismatch("found_value", got, want);
                case (want.status)
                    ST_FULL: n_full++;
                    ST_OK: n_hit++;
                    default: n_miss++;
                endcase
            end
        end
    end

    // ---- watchdog: cycles with no transfer on either side ----
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d items sent, %0d results, %0d outstanding",
                     n_sent, n_recv, expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---- end of run ----
    initial begin
        wait (done_sending);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d transfers: %0d ok, %0d not found, %0d pool full",
                 n_recv, n_hit, n_miss, n_full);
        $display("table doubled %0d times, final size %0d, %0d mismatches",
                 n_grow, sh_size, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
